@@ rtl/fslp_pkg.sv @@
// ----------------------------------------------------------------------------
// fslp_pkg
// types and constants shared by the fixed slot free list pool
// ----------------------------------------------------------------------------
package fslp_pkg;

    localparam int SLOT_W  = 8;
    localparam int LINK_W  = SLOT_W + 1;
    localparam int CHUNK_W = 5;

    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 5'd5;
    localparam logic [CHUNK_W-1:0] CHUNK_MIN   = 5'd2;
    localparam logic [CHUNK_W-1:0] CHUNK_MAX   = 5'd16;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_ROOM = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [SLOT_W-1:0] free_slot;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              status;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CARVE,
        ST_EMIT
    } t_state;

endpackage

@@ rtl/fslp_ram.sv @@
// ----------------------------------------------------------------------------
// fslp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module fslp_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fixed_slot_free_list_pool.sv @@
// ----------------------------------------------------------------------------
// fixed_slot_free_list_pool
// fixed-size slot pool: linked free list in a link ram, bump pointer carving
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  request | in        | i_in_valid / o_in_ready | t_req  {req_type, free_slot}
//  result  | out       | o_out_valid / i_out_ready | t_res {slot, status}
//  config  | in        | i_cfg_we (no wait)     | i_cfg_wdata  chunk_size
//
//  a free needs no link ram read, a pop from the free list does one link ram read,
//  a carve writes one link per cycle for each slot after the first
//  one request is in flight at a time; results go to an output register, so a
//  new request is taken while the previous result still waits to be drained
//  a full output register holds the finished request in the emit state
//  reset clears head, carve pointer and chunk_size (to 5); the link ram needs
//  no clearing, every link is written before it is read
//
module fixed_slot_free_list_pool
    import fslp_pkg::*;
#(
    parameter int POOL_SLOTS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CHUNK_W-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_req               i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_res               o_out_data
);

    // usable pool, capped by the 8-bit slot field
    localparam int SLOT_LIMIT = (POOL_SLOTS < 256) ? POOL_SLOTS : 256;
    localparam int ADDR_W     = $clog2(SLOT_LIMIT);
    localparam logic [LINK_W-1:0] LIMIT_V = LINK_W'(SLOT_LIMIT);

    t_state             r_state, n_state;
    logic [CHUNK_W-1:0] r_cfg_chunk;
    logic [SLOT_W-1:0]  r_head, n_head;
    logic               r_head_valid, n_head_valid;
    logic [LINK_W-1:0]  r_carve, n_carve;
    logic [LINK_W-1:0]  r_base, n_base;
    logic [CHUNK_W-1:0] r_chunk, n_chunk;
    logic [CHUNK_W-1:0] r_idx, n_idx;
    t_res               r_res, n_res;
    logic               r_out_valid, n_out_valid;
    t_res               r_out, n_out;

    // link ram ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [LINK_W-1:0] ram_wdata;
    logic [LINK_W-1:0] ram_rdata;

    // request decode
    logic               accept;
    logic               out_free;
    logic               free_in_range;
    logic [CHUNK_W-1:0] eff_chunk;
    logic [LINK_W-1:0]  room_left;
    logic               has_room;
    logic               carve_last;
    logic [LINK_W-1:0]  carve_addr;
    logic [LINK_W-1:0]  carve_next;
    logic               done;

    fslp_ram #(
        .WIDTH (LINK_W),
        .DEPTH (SLOT_LIMIT)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_head[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // chunk size clamped to 2..16
    always_comb begin
        eff_chunk = r_cfg_chunk;
        if (r_cfg_chunk < CHUNK_MIN) begin
            eff_chunk = CHUNK_MIN;
        end else if (r_cfg_chunk > CHUNK_MAX) begin
            eff_chunk = CHUNK_MAX;
        end
    end

    assign free_in_range = ({1'b0, i_in_data.free_slot} < LIMIT_V);
    assign room_left     = LIMIT_V - r_carve;
    assign has_room      = (r_carve <= LIMIT_V) &&
                           (room_left >= {{(LINK_W-CHUNK_W){1'b0}}, eff_chunk});
    assign carve_addr    = r_base + {{(LINK_W-CHUNK_W){1'b0}}, r_idx};
    assign carve_next    = carve_addr + LINK_W'(1);
    assign carve_last    = (r_idx == (r_chunk - CHUNK_W'(1)));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_data.req_type == REQ_FREE || !has_room) begin
                        n_state = out_free ? ST_IDLE : ST_EMIT;
                    end else if (r_head_valid) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_CARVE;
                    end
                    // a pop from a non-empty list reads the link, room or not
                    if (i_in_data.req_type == REQ_ALLOC && r_head_valid) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = out_free ? ST_IDLE : ST_EMIT;
            end
            ST_CARVE: begin
                if (carve_last) begin
                    n_state = out_free ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and link ram control
    always_comb begin
        n_head       = r_head;
        n_head_valid = r_head_valid;
        n_carve      = r_carve;
        n_base       = r_base;
        n_chunk      = r_chunk;
        n_idx        = r_idx;
        n_res        = r_res;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        done         = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_data.req_type == REQ_FREE) begin
                        // push onto the head; beyond-pool frees only echo
                        if (free_in_range) begin
                            ram_we       = 1'b1;
                            ram_waddr    = i_in_data.free_slot[ADDR_W-1:0];
                            ram_wdata    = {r_head_valid, r_head};
                            n_head       = i_in_data.free_slot;
                            n_head_valid = 1'b1;
                        end
                        n_res = '{slot: i_in_data.free_slot, status: STATUS_OK};
                        done  = 1'b1;
                    end else if (r_head_valid) begin
                        // pop: link of the head is read this cycle
                        n_res = '{slot: r_head, status: STATUS_OK};
                    end else if (!has_room) begin
                        n_res = '{slot: '0, status: STATUS_NO_ROOM};
                        done  = 1'b1;
                    end else begin
                        // carve: hand out base, base+1 becomes the head
                        n_res        = '{slot: r_carve[SLOT_W-1:0], status: STATUS_OK};
                        n_head       = SLOT_W'(r_carve + LINK_W'(1));
                        n_head_valid = 1'b1;
                        n_base       = r_carve;
                        n_chunk      = eff_chunk;
                        n_idx        = CHUNK_W'(1);
                        n_carve      = r_carve + {{(LINK_W-CHUNK_W){1'b0}}, eff_chunk};
                    end
                end
            end
            ST_READ: begin
                n_head       = ram_rdata[SLOT_W-1:0];
                n_head_valid = ram_rdata[SLOT_W];
                done         = 1'b1;
            end
            ST_CARVE: begin
                // links base+1 .. base+c-1, the last one null
                ram_we    = 1'b1;
                ram_waddr = carve_addr[ADDR_W-1:0];
                ram_wdata = carve_last ? '0 : {1'b1, carve_next[SLOT_W-1:0]};
                n_idx     = r_idx + CHUNK_W'(1);
                done      = carve_last;
            end
            ST_EMIT: begin
                done = 1'b1;
            end
            default: begin
                done = 1'b0;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (done && out_free) begin
            n_out_valid = 1'b1;
            n_out       = n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cfg_chunk  <= CHUNK_RESET;
            r_head       <= '0;
            r_head_valid <= 1'b0;
            r_carve      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_head_valid <= n_head_valid;
            r_carve      <= n_carve;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_cfg_chunk <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_chunk <= n_chunk;
        r_idx   <= n_idx;
        r_res   <= n_res;
        r_out   <= n_out;
    end

endmodule
